### hdl/height_color_gradient_defines.svh
// assertion macros for the height color gradient block
`ifndef HEIGHT_COLOR_GRADIENT_DEFINES_SVH
`define HEIGHT_COLOR_GRADIENT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define HCG_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hcg assertion failed");
// next-cycle implication
`define HCG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hcg assertion failed");
`else
`define HCG_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define HCG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/hcg_pkg.sv
`default_nettype none

package hcg_pkg;

    localparam int HEIGHT_W   = 16;
    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int NUM_LANES  = COLOR_W / CHAN_W;
    localparam int LEN_W      = 16;
    localparam int PROD_W     = LEN_W + CHAN_W;
    localparam int NUM_W      = PROD_W + 1;
    localparam int DEN_W      = LEN_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES = CHAN_W / DIV_BITS_PER_STAGE;
    // front, multiply, divider stages, output
    localparam int HCG_DEPTH  = DIV_STAGES + 3;
    localparam int CNT_W      = $clog2(HCG_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_HEIGHT   = 3'd0,
        REG_MIN_HEIGHT   = 3'd1,
        REG_TOP_COLOR    = 3'd2,
        REG_GROUND_COLOR = 3'd3,
        REG_BOTTOM_COLOR = 3'd4
    } hcg_reg_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic [COLOR_W-1:0]         own_color;
    } hcg_in_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               clamped;
    } hcg_out_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] max_height;
        logic signed [HEIGHT_W-1:0] min_height;
        logic [COLOR_W-1:0]         top_color;
        logic [COLOR_W-1:0]         ground_color;
        logic [COLOR_W-1:0]         bottom_color;
    } hcg_cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] start;
        logic              neg;
        logic [CHAN_W-1:0] mag;
    } hcg_lane_t;

    typedef struct packed {
        logic                         bypass;
        logic [COLOR_W-1:0]           fixed_color;
        logic                         clamped;
        logic [LEN_W-1:0]             len;
        logic [LEN_W-1:0]             pix;
        hcg_lane_t [NUM_LANES-1:0]    lane;
    } hcg_front_t;

    typedef struct packed {
        logic [CHAN_W-1:0] start;
        logic              neg;
        logic [NUM_W-1:0]  rem;
        logic [CHAN_W-1:0] quo;
    } hcg_div_lane_t;

    typedef struct packed {
        logic                           bypass;
        logic [COLOR_W-1:0]             fixed_color;
        logic                           clamped;
        logic [DEN_W-1:0]               den;
        hcg_div_lane_t [NUM_LANES-1:0]  lane;
    } hcg_div_t;

    typedef struct packed {
        logic             take;
        logic [NUM_W-1:0] rem;
    } hcg_step_t;

    // one restoring division step against den shifted left
    function automatic hcg_step_t div_step(input logic [NUM_W-1:0] rem,
                                           input logic [DEN_W-1:0] den,
                                           input int unsigned      shift);
        logic [NUM_W:0] dsh;
        logic [NUM_W:0] trial;
        hcg_step_t      res;
        dsh      = {{(NUM_W + 1 - DEN_W){1'b0}}, den} << shift;
        trial    = {1'b0, rem} - dsh;
        res.take = ~trial[NUM_W];
        res.rem  = res.take ? trial[NUM_W-1:0] : rem;
        return res;
    endfunction

endpackage

`default_nettype wire

### hdl/hcg_cfg_regs.sv
`default_nettype none

module hcg_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hcg_pkg::CFG_DATA_W-1:0] cfg_data,
    output hcg_pkg::hcg_cfg_t                   cfg
);

    hcg_pkg::hcg_cfg_t cfg_reg;
    hcg_pkg::hcg_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                hcg_pkg::REG_MAX_HEIGHT: begin
                    cfg_next.max_height = cfg_data[hcg_pkg::HEIGHT_W-1:0];
                end
                hcg_pkg::REG_MIN_HEIGHT: begin
                    cfg_next.min_height = cfg_data[hcg_pkg::HEIGHT_W-1:0];
                end
                hcg_pkg::REG_TOP_COLOR: begin
                    cfg_next.top_color = cfg_data[hcg_pkg::COLOR_W-1:0];
                end
                hcg_pkg::REG_GROUND_COLOR: begin
                    cfg_next.ground_color = cfg_data[hcg_pkg::COLOR_W-1:0];
                end
                hcg_pkg::REG_BOTTOM_COLOR: begin
                    cfg_next.bottom_color = cfg_data[hcg_pkg::COLOR_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### hdl/hcg_front.sv
`default_nettype none

module hcg_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire hcg_pkg::hcg_cfg_t   cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire hcg_pkg::hcg_in_t    in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output hcg_pkg::hcg_front_t      out_data
);

    logic                valid_reg;
    hcg_pkg::hcg_front_t data_reg;
    hcg_pkg::hcg_front_t data_next;

    logic signed [hcg_pkg::HEIGHT_W-1:0] hc;
    logic                                gt;
    logic                                lt;
    logic                                pos;
    logic [hcg_pkg::HEIGHT_W:0]          neg_len;
    logic [hcg_pkg::HEIGHT_W:0]          neg_pix;
    logic [hcg_pkg::COLOR_W-1:0]         start_c;
    logic [hcg_pkg::COLOR_W-1:0]         end_c;
    logic [hcg_pkg::CHAN_W:0]            diff;
    logic [hcg_pkg::CHAN_W:0]            ndiff;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        gt  = in_data.height > cfg.max_height;
        lt  = in_data.height < cfg.min_height;
        hc  = gt ? cfg.max_height : (lt ? cfg.min_height : in_data.height);
        pos = ~hc[hcg_pkg::HEIGHT_W-1];

        neg_len = '0 - {cfg.min_height[hcg_pkg::HEIGHT_W-1], cfg.min_height};
        neg_pix = {hc[hcg_pkg::HEIGHT_W-1], hc}
                - {cfg.min_height[hcg_pkg::HEIGHT_W-1], cfg.min_height};

        start_c = pos ? cfg.ground_color : cfg.bottom_color;
        end_c   = pos ? cfg.top_color    : cfg.ground_color;

        data_next.clamped     = gt || lt;
        data_next.bypass      = 1'b1;
        data_next.fixed_color = '0;
        if (in_data.own_color != '0) begin
            data_next.fixed_color = in_data.own_color;
        end else if (hc == cfg.max_height) begin
            data_next.fixed_color = cfg.top_color;
        end else if (hc == '0) begin
            data_next.fixed_color = cfg.ground_color;
        end else if (hc == cfg.min_height && cfg.min_height != '0) begin
            data_next.fixed_color = cfg.bottom_color;
        end else begin
            data_next.bypass = 1'b0;
        end

        data_next.len = pos ? cfg.max_height : neg_len[hcg_pkg::LEN_W-1:0];
        data_next.pix = pos ? hc             : neg_pix[hcg_pkg::LEN_W-1:0];

        for (int k = 0; k < hcg_pkg::NUM_LANES; k++) begin
            diff  = {1'b0, end_c[k*hcg_pkg::CHAN_W +: hcg_pkg::CHAN_W]}
                  - {1'b0, start_c[k*hcg_pkg::CHAN_W +: hcg_pkg::CHAN_W]};
            ndiff = '0 - diff;
            data_next.lane[k].start = start_c[k*hcg_pkg::CHAN_W +: hcg_pkg::CHAN_W];
            data_next.lane[k].neg   = diff[hcg_pkg::CHAN_W];
            data_next.lane[k].mag   = diff[hcg_pkg::CHAN_W] ? ndiff[hcg_pkg::CHAN_W-1:0]
                                                            : diff[hcg_pkg::CHAN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### hdl/hcg_mul.sv
`default_nettype none

module hcg_mul (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire hcg_pkg::hcg_front_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output hcg_pkg::hcg_div_t         out_data
);

    logic                          valid_reg;
    hcg_pkg::hcg_div_t             data_reg;
    hcg_pkg::hcg_div_t             data_next;
    logic [hcg_pkg::PROD_W-1:0]    prod;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // numerator 2*pix*|diff| + len and denominator 2*len give round half away
    always_comb begin
        data_next.bypass      = in_data.bypass;
        data_next.fixed_color = in_data.fixed_color;
        data_next.clamped     = in_data.clamped;
        data_next.den         = {in_data.len, 1'b0};
        for (int k = 0; k < hcg_pkg::NUM_LANES; k++) begin
            prod = in_data.pix * in_data.lane[k].mag;
            data_next.lane[k].start = in_data.lane[k].start;
            data_next.lane[k].neg   = in_data.lane[k].neg;
            data_next.lane[k].rem   = {prod, 1'b0}
                                    + {{(hcg_pkg::NUM_W - hcg_pkg::LEN_W){1'b0}}, in_data.len};
            data_next.lane[k].quo   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### hdl/hcg_div_stage.sv
`default_nettype none

module hcg_div_stage #(
    parameter int unsigned HI_SHIFT = hcg_pkg::CHAN_W - 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hcg_pkg::hcg_div_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hcg_pkg::hcg_div_t       out_data
);

    logic                valid_reg;
    hcg_pkg::hcg_div_t   data_reg;
    hcg_pkg::hcg_div_t   data_next;
    hcg_pkg::hcg_step_t  step;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // two quotient bits per stage (DIV_BITS_PER_STAGE), msb first
    always_comb begin
        data_next = in_data;
        for (int k = 0; k < hcg_pkg::NUM_LANES; k++) begin
            for (int j = 0; j < hcg_pkg::DIV_BITS_PER_STAGE; j++) begin
                step = hcg_pkg::div_step(data_next.lane[k].rem, in_data.den,
                                         HI_SHIFT - j);
                data_next.lane[k].rem = step.rem;
                data_next.lane[k].quo = data_next.lane[k].quo
                    | ({{(hcg_pkg::CHAN_W - 1){1'b0}}, step.take} << (HI_SHIFT - j));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### hdl/hcg_back.sv
`default_nettype none

module hcg_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hcg_pkg::hcg_div_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hcg_pkg::hcg_out_t       out_data
);

    logic                         valid_reg;
    hcg_pkg::hcg_out_t            data_reg;
    hcg_pkg::hcg_out_t            data_next;
    logic [hcg_pkg::COLOR_W-1:0]  blended;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        for (int k = 0; k < hcg_pkg::NUM_LANES; k++) begin
            blended[k*hcg_pkg::CHAN_W +: hcg_pkg::CHAN_W] = in_data.lane[k].neg
                ? in_data.lane[k].start - in_data.lane[k].quo
                : in_data.lane[k].start + in_data.lane[k].quo;
        end
        data_next.color   = in_data.bypass ? in_data.fixed_color : blended;
        data_next.clamped = in_data.clamped;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

### hdl/height_color_gradient.sv
// height color gradient: maps a signed map height (plus an optional own
// color) to a 24-bit rgb color. a nonzero own color passes through; else the
// height is clamped to [min_height, max_height] and colored from the three
// configured colors, interpolating per 8-bit channel with exact rounding half
// away from zero. throughput is one transaction per cycle while m_ready does
// not stall; an accepted input passes through the front select, multiply, four
// divider stages of two quotient bits each, and the output register. the
// divider is what sets the depth. a stall on m_ready only backs up full
// stages, bubbles collapse. the configuration port is always ready; write it
// only while no transaction is in flight.
`default_nettype none
`include "height_color_gradient_defines.svh"

module height_color_gradient (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hcg_pkg::CFG_DATA_W-1:0] cfg_data,
    // input points
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire hcg_pkg::hcg_in_t               s_data,
    // output colors
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output hcg_pkg::hcg_out_t                   m_data
);

    hcg_pkg::hcg_cfg_t   cfg;

    // front stage to multiplier
    logic                front_valid;
    logic                front_ready;
    hcg_pkg::hcg_front_t front_data;

    // divider chain, index 0 is the multiplier output
    logic                div_valid [hcg_pkg::DIV_STAGES+1];
    logic                div_ready [hcg_pkg::DIV_STAGES+1];
    hcg_pkg::hcg_div_t   div_data  [hcg_pkg::DIV_STAGES+1];

    // in-flight transaction count, used by the checks below
    logic [hcg_pkg::CNT_W-1:0] count_reg;
    logic [hcg_pkg::CNT_W-1:0] count_next;
    logic                      s_acc;
    logic                      m_acc;

    hcg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // clamp, case select, start color and channel differences
    hcg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    // pix times |diff| per channel, forms rounding numerator
    hcg_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    // restoring divider, msb quotient bits first
    for (genvar g = 0; g < hcg_pkg::DIV_STAGES; g++) begin : g_div
        hcg_div_stage #(
            .HI_SHIFT (hcg_pkg::CHAN_W - 1 - g * hcg_pkg::DIV_BITS_PER_STAGE)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[g]),
            .in_ready  (div_ready[g]),
            .in_data   (div_data[g]),
            .out_valid (div_valid[g+1]),
            .out_ready (div_ready[g+1]),
            .out_data  (div_data[g+1])
        );
    end

    // add signed quotient to start, output register
    hcg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid[hcg_pkg::DIV_STAGES]),
        .in_ready  (div_ready[hcg_pkg::DIV_STAGES]),
        .in_data   (div_data[hcg_pkg::DIV_STAGES]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    always_comb begin
        count_next = count_reg;
        if (s_acc && !m_acc) begin
            count_next = count_reg + 1'b1;
        end else if (!s_acc && m_acc) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // input only stalls when the output is held
    `HCG_ASSERT_IMPL(a_stall_from_output, aclk, aresetn, !s_ready, m_valid && !m_ready)
    // never more transactions in flight than stages
    `HCG_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= hcg_pkg::CNT_W'(hcg_pkg::HCG_DEPTH))
    // an output needs a transaction behind it
    `HCG_ASSERT_IMPL(a_valid_has_item, aclk, aresetn, m_valid, count_reg != '0)
    // last transaction taken with nothing entering leaves the output empty
    `HCG_ASSERT_NEXT(a_drain_empty, aclk, aresetn, m_acc && !s_acc && count_reg == hcg_pkg::CNT_W'(1), !m_valid)

endmodule

`default_nettype wire
